FILE: rtl/rvite_pkg.sv
// Shared types and constants for the RV32I I-type execute unit.
// Depends on nothing; rvite_if, rvite_exec and the top level use it.
`timescale 1ns / 1ps

package rvite_pkg;

  localparam int XLEN      = 32;
  localparam int NREGS     = 32;
  localparam int REG_AW    = 5;

  // Data memory: byte addressed, split into four byte lanes of equal depth.
  // The size is a power of two and at most 4096, so the preload address covers it.
  localparam int MEM_BYTES = 4096;
  localparam int MEM_AW    = $clog2(MEM_BYTES);
  localparam int LANES     = 4;
  localparam int ROWS      = MEM_BYTES / LANES;
  localparam int ROW_AW    = MEM_AW - 2;

  localparam logic KIND_EXEC    = 1'b0;
  localparam logic KIND_PRELOAD = 1'b1;

  localparam logic [6:0] OPC_LOAD  = 7'h03;
  localparam logic [6:0] OPC_OPIMM = 7'h13;
  localparam logic [6:0] OPC_JALR  = 7'h67;

  localparam logic [2:0] F3_JALR  = 3'd0;

  localparam logic [2:0] F3_LB    = 3'd0;
  localparam logic [2:0] F3_LH    = 3'd1;
  localparam logic [2:0] F3_LW    = 3'd2;
  localparam logic [2:0] F3_LBU   = 3'd4;
  localparam logic [2:0] F3_LHU   = 3'd5;

  localparam logic [2:0] F3_ADDI  = 3'd0;
  localparam logic [2:0] F3_SLLI  = 3'd1;
  localparam logic [2:0] F3_SLTI  = 3'd2;
  localparam logic [2:0] F3_SLTIU = 3'd3;
  localparam logic [2:0] F3_XORI  = 3'd4;
  localparam logic [2:0] F3_SRXI  = 3'd5;
  localparam logic [2:0] F3_ORI   = 3'd6;
  localparam logic [2:0] F3_ANDI  = 3'd7;

  localparam logic [6:0] F7_ZERO  = 7'h00;
  localparam logic [6:0] F7_SRA   = 7'h20;

  typedef struct packed {
    logic        kind;
    logic [31:0] instr_word;
    logic [31:0] pc_value;
    logic [11:0] preload_address;
    logic [7:0]  preload_byte;
  } in_word_t;

  typedef struct packed {
    logic               reg_written;
    logic [4:0]         dest_index;
    logic signed [31:0] dest_value;
    logic               jumped;
    logic [31:0]        next_pc;
    logic               illegal;
  } out_word_t;

  // Decoded and computed result of one item, handed from the execute logic to the top.
  typedef struct packed {
    logic              preload;
    logic              illegal;
    logic              wr;
    logic [REG_AW-1:0] rd;
    logic [XLEN-1:0]   value;
    logic              is_load;
    logic [2:0]        f3;
    logic [MEM_AW-1:0] addr;
    logic              jumped;
    logic [XLEN-1:0]   next_pc;
  } exec_t;

endpackage

FILE: rtl/rvite_if.sv
// Valid/ready channel interfaces for the instruction and result words.
// Depends on rvite_pkg for the payload types.
`timescale 1ns / 1ps

interface rvite_in_if;
  logic                valid;
  logic                ready;
  rvite_pkg::in_word_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

interface rvite_out_if;
  logic                 valid;
  logic                 ready;
  rvite_pkg::out_word_t payload;

  modport source(output valid, output payload, input ready);
  modport sink(input valid, input payload, output ready);
endinterface

FILE: rtl/rvite_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module rvite_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/rvite_exec.sv
// Decode and combinational compute of one I-type instruction or preload word.
// Depends on rvite_pkg.
`timescale 1ns / 1ps

module rvite_exec (
  input  rvite_pkg::in_word_t       item,
  input  logic [rvite_pkg::XLEN-1:0] opnd_a,
  output rvite_pkg::exec_t          ex
);
  import rvite_pkg::*;

  logic [31:0]       iw;
  logic [6:0]        opc;
  logic [4:0]        rd;
  logic [2:0]        f3;
  logic [4:0]        shamt;
  logic [6:0]        f7;
  logic [XLEN-1:0]   imm;
  logic [XLEN-1:0]   sum;
  logic [XLEN-1:0]   val;
  logic [XLEN-1:0]   npc;
  logic              ill;
  logic              jmp;
  logic              ld;
  logic              pre;

  assign iw    = item.instr_word;
  assign opc   = iw[6:0];
  assign rd    = iw[11:7];
  assign f3    = iw[14:12];
  assign shamt = iw[24:20];
  assign f7    = iw[31:25];
  assign imm   = {{20{iw[31]}}, iw[31:20]};
  assign sum   = opnd_a + imm;
  assign pre   = (item.kind == KIND_PRELOAD);

  always_comb begin
    val = '0;
    npc = item.pc_value;
    ill = 1'b0;
    jmp = 1'b0;
    ld  = 1'b0;
    unique case (opc)
      OPC_JALR: begin
        if (f3 == F3_JALR) begin
          val = item.pc_value;
          npc = sum;
          jmp = 1'b1;
        end else begin
          ill = 1'b1;
        end
      end
      OPC_LOAD: begin
        unique case (f3)
          F3_LB, F3_LH, F3_LW, F3_LBU, F3_LHU: ld = 1'b1;
          default: ill = 1'b1;
        endcase
      end
      OPC_OPIMM: begin
        unique case (f3)
          F3_ADDI:  val = sum;
          F3_SLTI:  val = {31'd0, $signed(opnd_a) < $signed(imm)};
          F3_SLTIU: val = {31'd0, opnd_a < imm};
          F3_XORI:  val = opnd_a ^ imm;
          F3_ORI:   val = opnd_a | imm;
          F3_ANDI:  val = opnd_a & imm;
          F3_SLLI: begin
            if (f7 == F7_ZERO) val = opnd_a << shamt;
            else ill = 1'b1;
          end
          F3_SRXI: begin
            if (f7 == F7_ZERO) val = opnd_a >> shamt;
            else if (f7 == F7_SRA) val = $unsigned($signed(opnd_a) >>> shamt);
            else ill = 1'b1;
          end
        endcase
      end
      default: ill = 1'b1;
    endcase
  end

  always_comb begin
    ex.preload = pre;
    ex.illegal = !pre && ill;
    ex.wr      = !pre && !ill && (rd != '0);
    ex.rd      = (pre || ill) ? '0 : rd;
    ex.value   = (pre || ill) ? '0 : val;
    ex.is_load = !pre && !ill && ld;
    ex.f3      = f3;
    ex.addr    = sum[MEM_AW-1:0];
    ex.jumped  = !pre && !ill && jmp;
    ex.next_pc = (pre || ill) ? item.pc_value : npc;
  end

endmodule

FILE: rtl/rv32i_itype_execute.sv
// Top level of the RV32I I-type execute unit: register file, byte data memory, pipeline.
// Depends on rvite_pkg, rvite_if, rvite_ram and rvite_exec.
`timescale 1ns / 1ps
//
//   Channel   Direction  Interface     Word carried
//   -------   ---------  ------------  ---------------------------------------------
//   instr     in         rvite_in_if   instruction to execute, or one byte to preload
//   result    out        rvite_out_if  register write, jump target and illegal flag
//
// One word is accepted per cycle while the result channel does not stall; each result
// passes through the input register (stage A) and then the result register (stage B).
// The result register is the only wait point; while it stalls, one more word is still
// taken into the input register before instr.ready drops.
// Reset (rst, synchronous) empties both stages and clears the register file to zero.
// The data memory is not cleared; a load of a byte that was never preloaded returns
// whatever the memory holds.

module rv32i_itype_execute (
  input  logic         clk,
  input  logic         rst,
  rvite_in_if.sink     instr,
  rvite_out_if.source  result
);
  import rvite_pkg::*;

  // Pipeline registers. Stage A holds the accepted word and does the decode and arithmetic;
  // stage B assembles load data and holds the finished result until the consumer takes it.
  logic                a_valid;
  in_word_t            a_item;
  logic                b_valid;
  out_word_t           b_out;
  logic                b_load;
  logic [2:0]          b_f3;
  logic [1:0]          b_off;

  logic                advance;
  logic                take;

  logic [XLEN-1:0]     rf [NREGS];
  logic [REG_AW-1:0]   rs1;
  logic                fwd;
  logic [XLEN-1:0]     b_value;
  logic [XLEN-1:0]     opnd_a;
  exec_t               ex;

  logic [XLEN-1:0]     ram_q;
  logic                ram_re;
  logic                pre_we;
  logic [MEM_AW-1:0]   pre_addr;

  // Assemble a little-endian load from the four lanes. Byte k of the access sits in lane
  // (offset + k) mod 4, so the bytes are rotated back into order before extension.
  function automatic logic [XLEN-1:0] load_value(input logic [XLEN-1:0] q,
                                                 input logic [1:0] off,
                                                 input logic [2:0] f3);
    logic [7:0]      by [LANES];
    logic [XLEN-1:0] v;
    for (int k = 0; k < LANES; k++) begin
      by[k] = q[{2'(off + 2'(k)), 3'b000} +: 8];
    end
    unique case (f3)
      F3_LB:   v = {{24{by[0][7]}}, by[0]};
      F3_LH:   v = {{16{by[1][7]}}, by[1], by[0]};
      F3_LW:   v = {by[3], by[2], by[1], by[0]};
      F3_LBU:  v = {24'd0, by[0]};
      F3_LHU:  v = {16'd0, by[1], by[0]};
      default: v = '0;
    endcase
    return v;
  endfunction

  // Stage B moves when it is empty or its word is being taken; stage A then moves with it.
  assign advance     = !b_valid || result.ready;
  assign instr.ready = !a_valid || advance;
  assign take        = instr.valid && instr.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (take) begin
      a_valid <= 1'b1;
    end else if (advance) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      a_item <= instr.payload;
    end
  end

  // The value of a pending load is known only in stage B, from the registered memory
  // read. The register file is written when the result word leaves, so the word in
  // stage B is the only one the operand read may have to bypass.
  assign b_value = b_load ? load_value(ram_q, b_off, b_f3) : b_out.dest_value;
  assign rs1     = a_item.instr_word[19:15];
  assign fwd     = b_valid && b_out.reg_written && (b_out.dest_index == rs1);
  assign opnd_a  = fwd ? b_value : rf[rs1];

  rvite_exec u_exec (
    .item   (a_item),
    .opnd_a (opnd_a),
    .ex     (ex)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (advance) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b_out.reg_written <= ex.wr;
      b_out.dest_index  <= ex.rd;
      b_out.dest_value  <= ex.value;
      b_out.jumped      <= ex.jumped;
      b_out.next_pc     <= ex.next_pc;
      b_out.illegal     <= ex.illegal;
      b_load            <= ex.is_load;
      b_f3              <= ex.f3;
      b_off             <= ex.addr[1:0];
    end
  end

  assign result.valid = b_valid;
  always_comb begin
    result.payload            = b_out;
    result.payload.dest_value = b_value;
  end

  // Register file: x0 is never written, so it always reads zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NREGS; i++) begin
        rf[i] <= '0;
      end
    end else if (result.valid && result.ready && b_out.reg_written) begin
      rf[b_out.dest_index] <= b_value;
    end
  end

  // Data memory as four byte lanes. A word access at byte offset off reads the row above
  // for every lane below off; the row index wraps, which gives the modulo-size addressing.
  // A read is issued only when stage A moves, so the read data stays put during a stall.
  assign ram_re   = a_valid && advance && ex.is_load;
  assign pre_we   = a_valid && advance && ex.preload;
  assign pre_addr = a_item.preload_address[MEM_AW-1:0];

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    logic [ROW_AW-1:0] rd_row;
    assign rd_row = ex.addr[MEM_AW-1:2] + ROW_AW'(2'(j) < ex.addr[1:0]);

    rvite_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
    ) u_ram (
      .clk   (clk),
      .we    (pre_we && (pre_addr[1:0] == 2'(j))),
      .waddr (pre_addr[MEM_AW-1:2]),
      .wdata (a_item.preload_byte),
      .re    (ram_re),
      .raddr (rd_row),
      .rdata (ram_q[8*j +: 8])
    );
  end

  // A word taken in always lands in stage A.
  a_take_fills: assert property (@(posedge clk) disable iff (rst)
    take |=> a_valid)
    else $error("accepted word did not reach the input stage");

  // A stalled result word, load data included, must not change while it waits.
  result_held: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |=> $stable(result.payload))
    else $error("result word changed while stalled");

  // A delivered register write lands in the register file.
  rf_write_lands: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.ready && result.payload.reg_written) |=>
      (rf[$past(result.payload.dest_index)] == $unsigned($past(result.payload.dest_value))))
    else $error("register file does not hold the delivered value");

  // x0 stays zero.
  x0_zero: assert property (@(posedge clk) disable iff (rst)
    rf[0] == '0)
    else $error("register x0 was written");

endmodule

FILE: verif/tb_rv32i_itype_execute.sv
`timescale 1ns / 1ps
// Testbench for rv32i_itype_execute: directed and random instruction and preload words,
// predicted by a small scoreboard class and checked field by field on the result channel.
// Depends on rvite_pkg, rvite_if and the RTL of the block.

module tb_rv32i_itype_execute;
  import rvite_pkg::*;

  // Encodings outside the covered set, used to provoke the illegal flag.
  localparam logic [6:0] OPC_REG  = 7'h33;
  localparam logic [6:0] F7_MUL   = 7'h01;
  localparam logic [2:0] F3_RSV3  = 3'd3;
  localparam logic [2:0] F3_RSV6  = 3'd6;
  localparam logic [2:0] F3_RSV7  = 3'd7;

  localparam int ITEMS_TARGET = 650;
  localparam int DRAIN_EVERY  = 160;

  // Architectural state of the unit plus the results it must still produce, in order.
  class itype_ledger;
    logic [31:0] regs [NREGS];
    logic [7:0]  mem [MEM_BYTES];
    out_word_t   awaited [$];
    int unsigned mismatches;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (mem[i]) mem[i] = '0;
      mismatches = 0;
    endfunction

    function logic [7:0] mem_at(logic [31:0] addr, int off);
      logic [31:0] a;
      a = addr + off;
      return mem[a % MEM_BYTES];
    endfunction

    // Executes one accepted word against the local state and queues its result.
    function void record_word(in_word_t w);
      out_word_t   e;
      logic [6:0]  opc;
      logic [6:0]  f7;
      logic [4:0]  rd;
      logic [4:0]  rs1;
      logic [4:0]  shamt;
      logic [2:0]  f3;
      logic [31:0] imm;
      logic [31:0] a;
      logic [31:0] ea;
      logic [31:0] val;
      logic [7:0]  b0, b1, b2, b3;
      logic        bad;
      e = '0;
      e.next_pc = w.pc_value;
      if (w.kind == KIND_PRELOAD) begin
        mem[w.preload_address % MEM_BYTES] = w.preload_byte;
        awaited.push_back(e);
        return;
      end
      opc   = w.instr_word[6:0];
      rd    = w.instr_word[11:7];
      f3    = w.instr_word[14:12];
      rs1   = w.instr_word[19:15];
      shamt = w.instr_word[24:20];
      f7    = w.instr_word[31:25];
      imm   = {{20{w.instr_word[31]}}, w.instr_word[31:20]};
      a     = regs[rs1];
      ea    = a + imm;
      b0    = mem_at(ea, 0);
      b1    = mem_at(ea, 1);
      b2    = mem_at(ea, 2);
      b3    = mem_at(ea, 3);
      val   = '0;
      bad   = 1'b0;
      unique case (opc)
        OPC_JALR: begin
          if (f3 == F3_JALR) begin
            val = w.pc_value;
            e.jumped = 1'b1;
            e.next_pc = a + imm;
          end else begin
            bad = 1'b1;
          end
        end
        OPC_LOAD: begin
          unique case (f3)
            F3_LB:   val = {{24{b0[7]}}, b0};
            F3_LH:   val = {{16{b1[7]}}, b1, b0};
            F3_LW:   val = {b3, b2, b1, b0};
            F3_LBU:  val = {24'd0, b0};
            F3_LHU:  val = {16'd0, b1, b0};
            default: bad = 1'b1;
          endcase
        end
        OPC_OPIMM: begin
          unique case (f3)
            F3_ADDI:  val = a + imm;
            F3_SLTI:  val = ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0;
            F3_SLTIU: val = (a < imm) ? 32'd1 : 32'd0;
            F3_XORI:  val = a ^ imm;
            F3_ORI:   val = a | imm;
            F3_ANDI:  val = a & imm;
            F3_SLLI: begin
              if (f7 == F7_ZERO) val = a << shamt;
              else bad = 1'b1;
            end
            default: begin
              if (f7 == F7_ZERO) val = a >> shamt;
              else if (f7 == F7_SRA) val = $signed(a) >>> shamt;
              else bad = 1'b1;
            end
          endcase
        end
        default: bad = 1'b1;
      endcase
      if (bad) begin
        e.jumped = 1'b0;
        e.next_pc = w.pc_value;
        e.illegal = 1'b1;
      end else begin
        if (rd != 5'd0) regs[rd] = val;
        e.reg_written = (rd != 5'd0);
        e.dest_index = rd;
        e.dest_value = val;
      end
      awaited.push_back(e);
    endfunction

    function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%08h, actual 0x%08h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_word(out_word_t g);
      out_word_t e;
      if (awaited.size() == 0) begin
        $error("result word arrived with no prediction waiting");
        mismatches++;
        return;
      end
      e = awaited.pop_front();
      cmp_field("reg_written", 32'(e.reg_written), 32'(g.reg_written));
      cmp_field("dest_index", 32'(e.dest_index), 32'(g.dest_index));
      cmp_field("dest_value", e.dest_value, g.dest_value);
      cmp_field("jumped", 32'(e.jumped), 32'(g.jumped));
      cmp_field("next_pc", e.next_pc, g.next_pc);
      cmp_field("illegal", 32'(e.illegal), 32'(g.illegal));
    endfunction
  endclass

  logic clk;
  logic rst;

  rvite_in_if  instr_ch ();
  rvite_out_if result_ch ();

  rv32i_itype_execute dut (
    .clk    (clk),
    .rst    (rst),
    .instr  (instr_ch),
    .result (result_ch)
  );

  itype_ledger ledger = new();

  // Bytes that have been preloaded, and start addresses of four written bytes in a row.
  // Random loads are aimed only inside such a run, so no unwritten byte is read.
  bit          byte_set [MEM_BYTES];
  int          load_bases [$];
  int unsigned words_sent = 0;
  bit          steady_send = 1'b0;
  bit          steady_recv = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] enc_i(logic [6:0] opc, logic [4:0] rd, logic [2:0] f3,
                                        logic [4:0] rs1, logic [11:0] imm);
    return {imm, rs1, f3, rd, opc};
  endfunction

  // Immediate that makes rs1 + imm land on the target byte, given rs1's current value.
  function automatic logic [11:0] reach(logic [4:0] rs1, int target);
    logic [31:0] d;
    d = target - ledger.regs[rs1];
    return d[11:0];
  endfunction

  function automatic logic [31:0] pick_pc();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 32'h0000_0000;
    if (r == 1) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Offers one word, with a random gap before it, and records it once accepted.
  task automatic send_word(in_word_t w);
    int gap;
    gap = steady_send ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      instr_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    instr_ch.valid   <= 1'b1;
    instr_ch.payload <= w;
    do @(posedge clk); while (!instr_ch.ready);
    ledger.record_word(w);
    words_sent++;
    if (words_sent % 50 == 0) steady_send = ($urandom_range(0, 3) == 0);
  endtask

  task automatic exec(logic [31:0] iw, logic [31:0] pc);
    in_word_t w;
    w.kind            = KIND_EXEC;
    w.instr_word      = iw;
    w.pc_value        = pc;
    w.preload_address = 12'($urandom);
    w.preload_byte    = 8'($urandom);
    send_word(w);
  endtask

  task automatic preload(logic [11:0] addr, logic [7:0] b);
    in_word_t w;
    int       base;
    bit       full;
    w.kind            = KIND_PRELOAD;
    w.instr_word      = $urandom;
    w.pc_value        = $urandom;
    w.preload_address = addr;
    w.preload_byte    = b;
    byte_set[int'(addr) % MEM_BYTES] = 1'b1;
    for (int k = 0; k < 4; k++) begin
      base = (int'(addr) - k + MEM_BYTES) % MEM_BYTES;
      full = 1'b1;
      for (int j = 0; j < 4; j++) begin
        if (!byte_set[(base + j) % MEM_BYTES]) full = 1'b0;
      end
      if (full) load_bases.push_back(base);
    end
    send_word(w);
  endtask

  task automatic preload_burst();
    int base;
    base = $urandom_range(0, MEM_BYTES - 1);
    for (int k = 0; k < 4; k++) preload(12'((base + k) % MEM_BYTES), 8'($urandom));
  endtask

  task automatic rand_opimm();
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [11:0] imm;
    int          r;
    f3  = 3'($urandom_range(0, 7));
    r   = $urandom_range(0, 9);
    imm = 12'($urandom);
    if (r == 0) imm = 12'h800;
    else if (r == 1) imm = 12'h7FF;
    if (f3 == F3_SLLI) begin
      f7  = (r < 9) ? F7_ZERO : 7'($urandom);
      imm = {f7, imm[4:0]};
    end else if (f3 == F3_SRXI) begin
      f7  = (r < 9) ? ($urandom_range(0, 1) ? F7_SRA : F7_ZERO) : 7'($urandom);
      imm = {f7, imm[4:0]};
    end
    exec(enc_i(OPC_OPIMM, 5'($urandom), f3, 5'($urandom), imm), pick_pc());
  endtask

  task automatic rand_load();
    logic [2:0] f3;
    logic [4:0] rs1;
    int         base;
    int         target;
    int         sel;
    if (load_bases.size() == 0) begin
      preload_burst();
      return;
    end
    base = load_bases[$urandom_range(0, load_bases.size() - 1)];
    sel  = $urandom_range(0, 4);
    unique case (sel)
      0: begin f3 = F3_LB;  target = base + $urandom_range(0, 3); end
      1: begin f3 = F3_LBU; target = base + $urandom_range(0, 3); end
      2: begin f3 = F3_LH;  target = base + $urandom_range(0, 2); end
      3: begin f3 = F3_LHU; target = base + $urandom_range(0, 2); end
      default: begin f3 = F3_LW; target = base; end
    endcase
    rs1 = 5'($urandom);
    exec(enc_i(OPC_LOAD, 5'($urandom), f3, rs1, reach(rs1, target % MEM_BYTES)), pick_pc());
  endtask

  task automatic rand_jalr();
    logic [4:0] rs1;
    logic [4:0] rd;
    rs1 = 5'($urandom);
    rd  = ($urandom_range(0, 4) == 0) ? rs1 : 5'($urandom);
    exec(enc_i(OPC_JALR, rd, F3_JALR, rs1, 12'($urandom)), pick_pc());
  endtask

  // Broken or random encodings. A random word that decodes as a legal load is aimed
  // at preloaded bytes, or turned into an illegal load when nothing is preloaded yet.
  task automatic rand_noise();
    logic [31:0] iw;
    logic [2:0]  f3;
    int          r;
    int          r2;
    r  = $urandom_range(0, 3);
    iw = $urandom;
    unique case (r)
      1: begin
        iw[6:0]   = OPC_JALR;
        iw[14:12] = 3'($urandom_range(1, 7));
      end
      2: begin
        r2 = $urandom_range(0, 2);
        iw[6:0]   = OPC_LOAD;
        iw[14:12] = (r2 == 0) ? F3_RSV3 : ((r2 == 1) ? F3_RSV6 : F3_RSV7);
      end
      3: begin
        iw[6:0]   = OPC_OPIMM;
        iw[14:12] = $urandom_range(0, 1) ? F3_SLLI : F3_SRXI;
      end
      default: ;
    endcase
    f3 = iw[14:12];
    if (iw[6:0] == OPC_LOAD && (f3 == F3_LB || f3 == F3_LH || f3 == F3_LW ||
                                f3 == F3_LBU || f3 == F3_LHU)) begin
      if (load_bases.size() > 0)
        iw[31:20] = reach(iw[19:15], load_bases[$urandom_range(0, load_bases.size() - 1)]);
      else
        iw[14:12] = F3_RSV3;
    end
    exec(iw, pick_pc());
  endtask

  // Holds the sender back until every outstanding result has come out.
  task automatic drain();
    instr_ch.valid <= 1'b0;
    do @(posedge clk); while (ledger.awaited.size() > 0);
  endtask

  // Result side: random stall before each word, with stretches of steady acceptance.
  initial begin
    int          stall;
    int unsigned got;
    got = 0;
    result_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = steady_recv ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      ledger.check_word(result_ch.payload);
      got++;
      if (got % 40 == 0) steady_recv = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin
    int next_drain;
    int pick;
    rst              <= 1'b1;
    instr_ch.valid   <= 1'b0;
    instr_ch.payload <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Preload four bytes across the top of memory so a word load wraps to address 0.
    preload(12'hFFE, 8'h80);
    preload(12'hFFF, 8'hFF);
    preload(12'h000, 8'h7F);
    preload(12'h001, 8'h01);
    // Immediate extremes.
    exec(enc_i(OPC_OPIMM, 5'd1, F3_ADDI, 5'd0, 12'h800), 32'h0000_0000);
    exec(enc_i(OPC_OPIMM, 5'd2, F3_ADDI, 5'd0, 12'h7FF), 32'hFFFF_FFFF);
    // Every load width, at addresses near and across the end of memory.
    exec(enc_i(OPC_LOAD, 5'd3, F3_LW, 5'd0, 12'hFFE), pick_pc());
    exec(enc_i(OPC_LOAD, 5'd4, F3_LB, 5'd0, 12'hFFE), pick_pc());
    exec(enc_i(OPC_LOAD, 5'd5, F3_LH, 5'd0, 12'hFFE), pick_pc());
    exec(enc_i(OPC_LOAD, 5'd6, F3_LBU, 5'd0, 12'hFFF), pick_pc());
    exec(enc_i(OPC_LOAD, 5'd7, F3_LHU, 5'd0, 12'hFFF), pick_pc());
    // Compares, logic and shifts on a negative and a positive operand.
    exec(enc_i(OPC_OPIMM, 5'd8, F3_SLTI, 5'd1, 12'hFFF), pick_pc());
    exec(enc_i(OPC_OPIMM, 5'd9, F3_SLTIU, 5'd1, 12'hFFF), pick_pc());
    exec(enc_i(OPC_OPIMM, 5'd11, F3_XORI, 5'd3, 12'hFFF), pick_pc());
    exec(enc_i(OPC_OPIMM, 5'd12, F3_ORI, 5'd1, 12'h7FF), pick_pc());
    exec(enc_i(OPC_OPIMM, 5'd13, F3_ANDI, 5'd3, 12'h800), pick_pc());
    exec(enc_i(OPC_OPIMM, 5'd14, F3_SLLI, 5'd3, {F7_ZERO, 5'd31}), pick_pc());
    exec(enc_i(OPC_OPIMM, 5'd15, F3_SRXI, 5'd1, {F7_ZERO, 5'd31}), pick_pc());
    exec(enc_i(OPC_OPIMM, 5'd16, F3_SRXI, 5'd1, {F7_SRA, 5'd31}), pick_pc());
    // Shifts with a funct7 that is not allowed.
    exec(enc_i(OPC_OPIMM, 5'd17, F3_SLLI, 5'd3, {F7_SRA, 5'd4}), pick_pc());
    exec(enc_i(OPC_OPIMM, 5'd18, F3_SRXI, 5'd3, {F7_MUL, 5'd4}), pick_pc());
    // A write to x0 is dropped but still reported.
    exec(enc_i(OPC_OPIMM, 5'd0, F3_ADDI, 5'd2, 12'h005), pick_pc());
    // jalr whose destination is its own source, with an odd target, then one into x0.
    exec(enc_i(OPC_JALR, 5'd3, F3_JALR, 5'd3, 12'h001), 32'h0000_0000);
    exec(enc_i(OPC_JALR, 5'd0, F3_JALR, 5'd1, 12'hFFF), 32'hFFFF_FFFF);
    // Encodings outside the covered set.
    exec(enc_i(OPC_JALR, 5'd19, F3_RSV3, 5'd1, 12'h010), pick_pc());
    exec(enc_i(OPC_LOAD, 5'd20, F3_RSV3, 5'd0, 12'hFFE), pick_pc());
    exec(enc_i(OPC_REG, 5'd21, F3_ADDI, 5'd1, 12'h000), pick_pc());

    // Random part: mostly well-formed instructions against preloaded memory.
    next_drain = DRAIN_EVERY;
    while (words_sent < ITEMS_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) preload_burst();
      else if (pick < 55) rand_opimm();
      else if (pick < 78) rand_load();
      else if (pick < 88) rand_jalr();
      else rand_noise();
      if (words_sent >= next_drain) begin
        drain();
        next_drain += DRAIN_EVERY;
      end
    end

    instr_ch.valid <= 1'b0;
    do @(posedge clk); while (ledger.awaited.size() > 0);
    repeat (16) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.awaited.size() == 0) begin
      $display("PASS rv32i_itype_execute");
    end else begin
      $display("FAIL rv32i_itype_execute");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL rv32i_itype_execute");
    $finish;
  end

endmodule
